/* design/tsm_pkg.sv */
`default_nettype none
package tsm_pkg;

   localparam int VALUE_W       = 32;
   localparam int ACTION_W      = 2;
   localparam int DEF_STORE_DEPTH = 16;

   typedef logic signed [VALUE_W-1:0] value_type;
   typedef logic [ACTION_W-1:0]       action_type;

   // action codes
   localparam action_type ACT_PUSH_A = 2'd0;
   localparam action_type ACT_PUSH_B = 2'd1;
   localparam action_type ACT_MERGE  = 2'd2;

   typedef struct packed {
      action_type action;
      value_type  value;
   } req_type;

   typedef struct packed {
      value_type merged_value;
      logic      from_b;
      logic      last;
   } rsp_type;

endpackage
`default_nettype wire

/* design/two_stack_merge_top.sv */
`default_nettype none
// Two LIFO stores, A and B, filled by push items and drained by a merge item.
// Input channel req_*: one item carries an action (push A, push B, merge) and
// a signed 32-bit value. A push to a full store is dropped silently; the
// unused action code is ignored.
// Result channel rsp_*: a merge emits one item per stored element. While both
// stores hold values the larger top is emitted (ties go to A), then the rest
// of A top to bottom, then the rest of B. The final item has last set. A
// merge of two empty stores emits nothing.
// Timing: a push leaves the block idle, so req_stall stays low. A merge
// keeps req_stall high until its final element is popped: one pop per cycle
// while the result register is free, through the single signed comparator
// on the two tops. Once the merge item is accepted the state register enters
// merge, and the first result is then written to the output register. Results
// sit there, so a push may be taken while a result still waits. While a held
// result sees rsp_stall high the sequencer holds and the register keeps it.
// Reset (synchronous, active high) empties both stores and clears rsp_valid;
// stored data is not cleared and needs no pass.
module two_stack_merge_top #(
   parameter int STORE_DEPTH = tsm_pkg::DEF_STORE_DEPTH
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  wire tsm_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output tsm_pkg::rsp_type rsp_data
);
   import tsm_pkg::*;

   localparam int CNT_W = $clog2(STORE_DEPTH + 1);
   localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STORE_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

   typedef enum logic {
      ST_IDLE,
      ST_MERGE
   } state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] count_a_ff, count_a_in;
   logic [CNT_W-1:0] count_b_ff, count_b_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   value_type store_a [STORE_DEPTH];
   value_type store_b [STORE_DEPTH];

   logic             req_take;
   logic             out_free;
   logic             wr_a, wr_b;
   logic [CNT_W-1:0] top_a_cnt, top_b_cnt;
   value_type        top_a, top_b;
   logic             a_nonempty, b_nonempty;
   logic             pick_a;
   logic             final_pop;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign wr_a = req_take && (req_data.action == ACT_PUSH_A) && (count_a_ff != CNT_FULL);
   assign wr_b = req_take && (req_data.action == ACT_PUSH_B) && (count_b_ff != CNT_FULL);

   // store tops
   assign top_a_cnt = count_a_ff - CNT_ONE;
   assign top_b_cnt = count_b_ff - CNT_ONE;
   assign top_a     = store_a[top_a_cnt[IDX_W-1:0]];
   assign top_b     = store_b[top_b_cnt[IDX_W-1:0]];

   assign a_nonempty = (count_a_ff != '0);
   assign b_nonempty = (count_b_ff != '0);

   // shared comparator: A wins ties, and wins whenever B is empty
   assign pick_a = a_nonempty && (!b_nonempty || (top_a >= top_b));

   // exactly one element left across both stores
   assign final_pop = (count_a_ff == CNT_ONE && !b_nonempty) ||
                      (count_b_ff == CNT_ONE && !a_nonempty);

   always_comb begin
      state_in     = state_ff;
      count_a_in   = count_a_ff;
      count_b_in   = count_b_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (wr_a) begin
               count_a_in = count_a_ff + CNT_ONE;
            end
            if (wr_b) begin
               count_b_in = count_b_ff + CNT_ONE;
            end
            if (req_take && req_data.action == ACT_MERGE && (a_nonempty || b_nonempty)) begin
               state_in = ST_MERGE;
            end
         end
         ST_MERGE: begin
            if (out_free) begin
               rsp_valid_in          = 1'b1;
               rsp_data_in.last      = final_pop;
               if (pick_a) begin
                  rsp_data_in.merged_value = top_a;
                  rsp_data_in.from_b       = 1'b0;
                  count_a_in               = count_a_ff - CNT_ONE;
               end else begin
                  rsp_data_in.merged_value = top_b;
                  rsp_data_in.from_b       = 1'b1;
                  count_b_in               = count_b_ff - CNT_ONE;
               end
               if (final_pop) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_a_ff   <= '0;
         count_b_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_a_ff   <= count_a_in;
         count_b_ff   <= count_b_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   // store writes; data needs no reset
   always_ff @(posedge clock) begin
      if (wr_a) begin
         store_a[count_a_ff[IDX_W-1:0]] <= req_data.value;
      end
      if (wr_b) begin
         store_b[count_b_ff[IDX_W-1:0]] <= req_data.value;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
